@@ rtl/oidba_pkg.sv @@
// Shared types, constants and search functions of the object id bitmap allocator.
`default_nettype none

package oidba_pkg;

	localparam int NUM_KINDS  = 9;
	localparam int POOL_BITS  = 32;
	localparam int ID_BITS    = 7;
	localparam int KIND_W     = 4;
	localparam int SIZE_W     = 6;
	localparam int POOL_IDX_W = $clog2(POOL_BITS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = NUM_KINDS * ID_BITS;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_CHECK = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NO_ENTRY = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_THREAD_KIND = 3'd4;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [KIND_W-1:0]  kind;
		logic [ID_BITS-1:0] object_id;
		logic [ID_BITS-1:0] target_id;
	} oidba_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [ID_BITS-1:0] granted_id;
		logic               is_allocated;
	} oidba_rsp_t;

	typedef struct packed {
		logic                  found;
		logic [POOL_IDX_W-1:0] idx;
	} oidba_hit_t;

	// lowest set bit
	function automatic oidba_hit_t find_low(input logic [POOL_BITS-1:0] v);
		oidba_hit_t h;
		h = '0;
		for (int i = POOL_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				h.found = 1'b1;
				h.idx   = POOL_IDX_W'(i);
			end
		end
		return h;
	endfunction

	// highest set bit
	function automatic oidba_hit_t find_high(input logic [POOL_BITS-1:0] v);
		oidba_hit_t h;
		h = '0;
		for (int i = 0; i < POOL_BITS; i++) begin
			if (v[i]) begin
				h.found = 1'b1;
				h.idx   = POOL_IDX_W'(i);
			end
		end
		return h;
	endfunction

	function automatic logic [POOL_BITS-1:0] size_mask(input logic [SIZE_W-1:0] n);
		logic [POOL_BITS-1:0] m;
		if (n >= SIZE_W'(POOL_BITS))
			m = '1;
		else
			m = (POOL_BITS'(1) << n) - POOL_BITS'(1);
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/object_id_bitmap_allocator.sv @@
// Object id bitmap allocator: per-kind used bitmaps with alloc, free, check and clear-all.
//
// Requests arrive on req/req_valid/req_stall and are taken at an edge where
// req_valid is high and req_stall is low. Each request produces exactly one
// response on rsp/rsp_valid/rsp_stall, taken when rsp_valid is high and
// rsp_stall is low. A request is captured in an input register; the bitmap lookup,
// priority search and bitmap update happen while it sits there and the response
// lands in the output register, which drives rsp_valid. One request per cycle is
// sustained while rsp is not stalled; the bitmap read-modify-write in that single
// stage sets the figure. While rsp is stalled the input stage still takes one
// request; a further request sees req_stall until the response is taken. Registers
// are written on the cfg channel (cfg_ready is always high); the user must write
// them only while the block is idle, which the block does not enforce. Reset clears
// all bitmaps, empties both stages and loads the register reset values (thread kind 1).
`default_nettype none

module object_id_bitmap_allocator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire oidba_pkg::oidba_req_t              req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output oidba_pkg::oidba_rsp_t                   rsp,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [oidba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [oidba_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import oidba_pkg::*;

	// configuration
	logic [ID_BITS-1:0]            id_count_q;
	logic [NUM_KINDS-1:0]          pool_enable_q;
	logic [NUM_KINDS*ID_BITS-1:0]  pool_bases_q;
	logic [NUM_KINDS*SIZE_W-1:0]   pool_sizes_q;
	logic [KIND_W-1:0]             thread_kind_q;

	logic [POOL_BITS-1:0] bitmaps_q [NUM_KINDS];

	oidba_req_t req_s1;
	logic       req_valid_s1;
	oidba_rsp_t rsp_q;
	logic       rsp_valid_q;

	logic accept, advance;

	logic [ID_BITS-1:0] base_a [NUM_KINDS];
	logic [SIZE_W-1:0]  size_a [NUM_KINDS];

	// datapath
	logic                  is_alloc, alloc_ok;
	logic [NUM_KINDS-1:0]  dec_cand, dec_win;
	logic                  dec_found;
	logic [KIND_W-1:0]     dec_kind;
	logic [ID_BITS-1:0]    dec_base;
	logic [KIND_W-1:0]     sel;
	logic                  sel_ok;
	logic [POOL_BITS-1:0]  bm;
	logic [ID_BITS-1:0]    base_sel;
	logic [SIZE_W-1:0]     size_sel;
	logic [POOL_BITS-1:0]  free_bits, lo_mask, hi_mask;
	logic [ID_BITS:0]      t;
	logic                  is_thread, t_neg, t_past, t_in;
	oidba_hit_t            lo_hit, hi_hit;
	logic                  alloc_found;
	logic [POOL_IDX_W-1:0] alloc_idx;
	logic [ID_BITS-1:0]    off;
	logic                  in_pool;
	logic                  wr_en;
	logic [POOL_BITS-1:0]  wr_data;
	oidba_rsp_t            rsp_d;
	logic                  all_clear;

	for (genvar k = 0; k < NUM_KINDS; k++) begin : g_unpack
		logic [SIZE_W-1:0] raw;
		assign raw       = pool_sizes_q[k*SIZE_W +: SIZE_W];
		assign base_a[k] = pool_bases_q[k*ID_BITS +: ID_BITS];
		assign size_a[k] = (raw > SIZE_W'(POOL_BITS)) ? SIZE_W'(POOL_BITS) : raw;
	end

	assign cfg_ready = 1'b1;
	assign advance   = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1 && rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// pool decode for free and check: largest base at or below the id
	always_comb begin
		for (int k = 0; k < NUM_KINDS; k++)
			dec_cand[k] = (req_s1.object_id < id_count_q) && (base_a[k] <= req_s1.object_id);
		for (int k = 0; k < NUM_KINDS; k++) begin
			dec_win[k] = dec_cand[k];
			for (int j = 0; j < NUM_KINDS; j++) begin
				if (j != k && dec_cand[j] && (base_a[j] > base_a[k] ||
						(base_a[j] == base_a[k] && j < k)))
					dec_win[k] = 1'b0;
			end
		end
		dec_found = |dec_cand;
		dec_kind  = '0;
		dec_base  = '0;
		for (int k = 0; k < NUM_KINDS; k++) begin
			if (dec_win[k]) begin
				dec_kind = dec_kind | KIND_W'(k);
				dec_base = dec_base | base_a[k];
			end
		end
	end

	always_comb begin
		is_alloc = (req_s1.cmd == CMD_ALLOC);
		alloc_ok = (req_s1.kind < KIND_W'(NUM_KINDS)) && pool_enable_q[req_s1.kind];
		sel      = is_alloc ? req_s1.kind : dec_kind;
		sel_ok   = sel < KIND_W'(NUM_KINDS);
		bm       = sel_ok ? bitmaps_q[sel] : '0;
		base_sel = sel_ok ? base_a[sel] : '0;
		size_sel = sel_ok ? size_a[sel] : '0;

		free_bits = ~(bm | ~size_mask(size_sel));
		t         = {1'b0, req_s1.target_id} - {1'b0, base_sel};
		is_thread = (req_s1.kind == thread_kind_q);
		t_neg     = t[ID_BITS];
		t_past    = !t_neg && (t[ID_BITS-1:0] >= {1'b0, size_sel});
		t_in      = is_thread && !t_neg && !t_past;

		if (t_in) begin
			lo_mask = '1 << t[POOL_IDX_W-1:0];
			hi_mask = '1 >> (POOL_IDX_W'(POOL_BITS - 1) - t[POOL_IDX_W-1:0]);
		end else if (is_thread && t_past) begin
			lo_mask = '0;
			hi_mask = '1;
		end else begin
			lo_mask = '1;
			hi_mask = '0;
		end
		lo_hit      = find_low(free_bits & lo_mask);
		hi_hit      = find_high(free_bits & hi_mask);
		alloc_found = lo_hit.found || hi_hit.found;
		alloc_idx   = lo_hit.found ? lo_hit.idx : hi_hit.idx;

		off     = req_s1.object_id - dec_base;
		in_pool = off < {1'b0, size_sel};

		rsp_d   = '0;
		wr_en   = 1'b0;
		wr_data = bm;
		case (req_s1.cmd)
			CMD_CLEAR: ;
			CMD_ALLOC: begin
				if (!alloc_ok) begin
					rsp_d.status = ST_INVALID;
				end else if (!alloc_found) begin
					rsp_d.status = ST_NO_ENTRY;
				end else begin
					wr_en              = 1'b1;
					wr_data[alloc_idx] = 1'b1;
					rsp_d.granted_id   = base_sel + ID_BITS'(alloc_idx);
				end
			end
			default: begin
				if (!dec_found) begin
					rsp_d.status = ST_INVALID;
				end else if (!in_pool) begin
					rsp_d.status = ST_NO_ENTRY;
				end else if (!pool_enable_q[dec_kind]) begin
					if (req_s1.cmd == CMD_FREE)
						rsp_d.status = ST_INVALID;
					else
						rsp_d.is_allocated = 1'b1;
				end else if (req_s1.cmd == CMD_FREE) begin
					wr_en                            = 1'b1;
					wr_data[off[POOL_IDX_W-1:0]]     = 1'b0;
				end else begin
					rsp_d.is_allocated = bm[off[POOL_IDX_W-1:0]];
				end
			end
		endcase

		all_clear = 1'b1;
		for (int k = 0; k < NUM_KINDS; k++)
			if (bitmaps_q[k] != '0)
				all_clear = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_count_q    <= '0;
			pool_enable_q <= '0;
			pool_bases_q  <= '0;
			pool_sizes_q  <= '0;
			thread_kind_q <= KIND_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ID_COUNT:    id_count_q    <= cfg_data[ID_BITS-1:0];
				CFG_POOL_ENABLE: pool_enable_q <= cfg_data[NUM_KINDS-1:0];
				CFG_POOL_BASES:  pool_bases_q  <= cfg_data[NUM_KINDS*ID_BITS-1:0];
				CFG_POOL_SIZES:  pool_sizes_q  <= cfg_data[NUM_KINDS*SIZE_W-1:0];
				CFG_THREAD_KIND: thread_kind_q <= cfg_data[KIND_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KINDS; k++)
				bitmaps_q[k] <= '0;
		end else if (advance) begin
			if (req_s1.cmd == CMD_CLEAR) begin
				for (int k = 0; k < NUM_KINDS; k++)
					bitmaps_q[k] <= '0;
			end else if (wr_en) begin
				bitmaps_q[sel] <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (accept)
				req_valid_s1 <= 1'b1;
			else if (advance)
				req_valid_s1 <= 1'b0;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_s1 <= req;
		if (advance)
			rsp_q <= rsp_d;
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> req_valid_s1 && rsp_valid_q)
		else $error("request stalled with a free stage");

	a_alloc_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_alloc && wr_en |=> bitmaps_q[$past(sel)][$past(alloc_idx)])
		else $error("granted entry not marked used");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.cmd == CMD_CLEAR |=> all_clear)
		else $error("clear all left a used entry");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_INVALID ||
			rsp.status == ST_NO_ENTRY)
		else $error("undefined status code");

	a_result_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.is_allocated || rsp.granted_id != '0) |-> rsp.status == ST_OK)
		else $error("result field set on a failed request");

endmodule

`default_nettype wire

@@ tb/object_id_bitmap_allocator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the object id bitmap allocator: directed table, random phases.
module object_id_bitmap_allocator_tb;
	import oidba_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int NUM_PHASES      = 8;
	localparam int MAX_REPORTS     = 10;
	localparam int QUIET_PHASE     = 3;
	localparam int IDLE_PCT        = 24;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	oidba_req_t            req       = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	oidba_rsp_t            rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	object_id_bitmap_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// allocator image
	logic [POOL_BITS-1:0]          used_map [NUM_KINDS];
	logic [ID_BITS-1:0]            m_id_count;
	logic [NUM_KINDS-1:0]          m_enable;
	logic [CFG_DATA_W-1:0]         m_bases;
	logic [NUM_KINDS*SIZE_W-1:0]   m_sizes;
	logic [KIND_W-1:0]             m_thread;

	oidba_rsp_t         rsp_due [$];
	logic [ID_BITS-1:0] granted_ids [$];
	oidba_rsp_t         head_rsp;
	int                 mismatches = 0;
	int                 cycles     = 0;
	bit                 quiet      = 1'b0;

	typedef struct packed {
		oidba_req_t r;
		logic       typed;
		oidba_rsp_t want;
	} stim_row_t;

	stim_row_t stim_table [$];
	int        reset_rows;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pool_len(input int k);
		int v;
		v = int'(m_sizes[SIZE_W*k +: SIZE_W]);
		return (v > POOL_BITS) ? POOL_BITS : v;
	endfunction

	function automatic int pool_first(input int k);
		return int'(m_bases[ID_BITS*k +: ID_BITS]);
	endfunction

	function automatic int lowest_free(input logic [POOL_BITS-1:0] used, input int start);
		for (int i = start; i < POOL_BITS; i++)
			if (!used[i])
				return i;
		return -1;
	endfunction

	function automatic int highest_free(input logic [POOL_BITS-1:0] used, input int start);
		int s;
		s = (start > POOL_BITS - 1) ? POOL_BITS - 1 : start;
		for (int i = s; i >= 0; i--)
			if (!used[i])
				return i;
		return -1;
	endfunction

	function automatic oidba_rsp_t predict_rsp(input oidba_req_t r);
		oidba_rsp_t           o;
		logic [POOL_BITS-1:0] used;
		int                   sz, base, t, idx, best, bestb, oid, b;
		bit                   found;
		o = '0;
		case (r.cmd)
			CMD_CLEAR: begin
				for (int k = 0; k < NUM_KINDS; k++)
					used_map[k] = '0;
			end
			CMD_ALLOC: begin
				if (int'(r.kind) >= NUM_KINDS) begin
					o.status = ST_INVALID;
				end else if (!m_enable[r.kind]) begin
					o.status = ST_INVALID;
				end else begin
					sz   = pool_len(r.kind);
					base = pool_first(r.kind);
					if (sz >= POOL_BITS)
						used = used_map[r.kind];
					else
						used = used_map[r.kind] | ~((32'(1) << sz) - 32'(1));
					if (r.kind == m_thread) begin
						t = int'(r.target_id) - base;
						if (t < 0) begin
							idx = lowest_free(used, 0);
						end else if (t >= sz) begin
							idx = highest_free(used, sz);
						end else begin
							idx = lowest_free(used, t);
							if (idx < 0)
								idx = highest_free(used, t);
						end
					end else begin
						idx = lowest_free(used, 0);
					end
					if (idx < 0) begin
						o.status = ST_NO_ENTRY;
					end else begin
						used_map[r.kind][idx] = 1'b1;
						o.granted_id = ID_BITS'(base + idx);
					end
				end
			end
			default: begin
				found = 1'b0;
				best  = 0;
				bestb = 0;
				oid   = int'(r.object_id);
				if (oid < int'(m_id_count)) begin
					for (int k = 0; k < NUM_KINDS; k++) begin
						b = pool_first(k);
						if (b <= oid && (!found || b > bestb)) begin
							found = 1'b1;
							best  = k;
							bestb = b;
						end
					end
				end
				if (!found) begin
					o.status = ST_INVALID;
				end else begin
					idx = oid - bestb;
					if (idx >= pool_len(best)) begin
						o.status = ST_NO_ENTRY;
					end else if (!m_enable[best]) begin
						if (r.cmd == CMD_FREE)
							o.status = ST_INVALID;
						else
							o.is_allocated = 1'b1;
					end else if (r.cmd == CMD_FREE) begin
						used_map[best][idx] = 1'b0;
					end else begin
						o.is_allocated = used_map[best][idx];
					end
				end
			end
		endcase
		return o;
	endfunction

	function automatic oidba_req_t random_req();
		oidba_req_t r;
		int         pick, tk;
		r.cmd       = CMD_CLEAR;
		r.kind      = KIND_W'($urandom());
		r.object_id = ID_BITS'($urandom());
		r.target_id = ID_BITS'($urandom());
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.cmd = CMD_ALLOC;
			tk = $urandom_range(99);
			if (tk < 30)
				r.kind = m_thread;
			else if (tk < 88)
				r.kind = KIND_W'($urandom_range(NUM_KINDS - 1));
			if (r.kind == m_thread && int'(m_thread) < NUM_KINDS && $urandom_range(99) < 60)
				r.target_id = ID_BITS'(pool_first(m_thread)
					+ $urandom_range(pool_len(m_thread) + 1));
		end else if (pick < 97) begin
			r.cmd = (pick < 70) ? CMD_FREE : CMD_CHECK;
			if (granted_ids.size() != 0 && $urandom_range(99) < 70)
				r.object_id = granted_ids[$urandom_range(granted_ids.size() - 1)];
		end
		return r;
	endfunction

	task automatic add_row(input logic [1:0] cmd, input int kind, input int oid, input int tgt,
			input bit typed, input logic [1:0] st, input int gid, input bit isal);
		stim_row_t row;
		row.r.cmd             = cmd;
		row.r.kind            = KIND_W'(kind);
		row.r.object_id       = ID_BITS'(oid);
		row.r.target_id       = ID_BITS'(tgt);
		row.typed             = typed;
		row.want.status       = st;
		row.want.granted_id   = ID_BITS'(gid);
		row.want.is_allocated = isal;
		stim_table.push_back(row);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_ID_COUNT:    m_id_count = data[ID_BITS-1:0];
			CFG_POOL_ENABLE: m_enable   = data[NUM_KINDS-1:0];
			CFG_POOL_BASES:  m_bases    = data;
			CFG_POOL_SIZES:  m_sizes    = data[NUM_KINDS*SIZE_W-1:0];
			CFG_THREAD_KIND: m_thread   = data[KIND_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// unused high bits of each write are random
	task automatic load_config(input logic [ID_BITS-1:0] ids, input logic [NUM_KINDS-1:0] en,
			input logic [CFG_DATA_W-1:0] bases, input logic [NUM_KINDS*SIZE_W-1:0] sizes,
			input logic [KIND_W-1:0] thr);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'({$urandom(), $urandom()});
		if ($urandom_range(1))
			write_reg(CFG_IDX_W'(CFG_THREAD_KIND + $urandom_range(3, 1)), d);
		d = CFG_DATA_W'({$urandom(), $urandom()});
		d[ID_BITS-1:0] = ids;
		write_reg(CFG_ID_COUNT, d);
		d = CFG_DATA_W'({$urandom(), $urandom()});
		d[NUM_KINDS-1:0] = en;
		write_reg(CFG_POOL_ENABLE, d);
		write_reg(CFG_POOL_BASES, bases);
		d = CFG_DATA_W'({$urandom(), $urandom()});
		d[NUM_KINDS*SIZE_W-1:0] = sizes;
		write_reg(CFG_POOL_SIZES, d);
		d = CFG_DATA_W'({$urandom(), $urandom()});
		d[KIND_W-1:0] = thr;
		write_reg(CFG_THREAD_KIND, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_config(input int thr_pick);
		logic [ID_BITS-1:0]          ids;
		logic [NUM_KINDS-1:0]        en;
		logic [CFG_DATA_W-1:0]       bases;
		logic [NUM_KINDS*SIZE_W-1:0] sizes;
		logic [KIND_W-1:0]           thr;
		int                          cursor, pick, sz;
		ids = ($urandom_range(99) < 80) ? ID_BITS'($urandom_range(127, 64))
			: ID_BITS'($urandom());
		for (int k = 0; k < NUM_KINDS; k++) begin
			en[k] = ($urandom_range(99) < 80);
			pick = $urandom_range(99);
			if (pick < 60)
				sizes[SIZE_W*k +: SIZE_W] = SIZE_W'($urandom_range(12, 1));
			else if (pick < 75)
				sizes[SIZE_W*k +: SIZE_W] = '0;
			else if (pick < 90)
				sizes[SIZE_W*k +: SIZE_W] = SIZE_W'($urandom_range(63, 33));
			else
				sizes[SIZE_W*k +: SIZE_W] = SIZE_W'($urandom_range(32, 13));
		end
		if ($urandom_range(99) < 75) begin
			cursor = $urandom_range(15);
			for (int k = 0; k < NUM_KINDS; k++) begin
				if (k > 0 && $urandom_range(99) < 10)
					bases[ID_BITS*k +: ID_BITS] = bases[ID_BITS*(k-1) +: ID_BITS];
				else
					bases[ID_BITS*k +: ID_BITS] = ID_BITS'(cursor);
				sz = int'(sizes[SIZE_W*k +: SIZE_W]);
				cursor = cursor + ((sz > POOL_BITS) ? POOL_BITS : sz) + $urandom_range(3);
			end
		end else begin
			bases = CFG_DATA_W'({$urandom(), $urandom()});
		end
		if (thr_pick >= 0)
			thr = KIND_W'(thr_pick);
		else if ($urandom_range(99) < 75)
			thr = KIND_W'($urandom_range(NUM_KINDS - 1));
		else
			thr = KIND_W'($urandom());
		load_config(ids, en, bases, sizes, thr);
	endtask

	task automatic drain();
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drive_req(input oidba_req_t r, input bit typed, input oidba_rsp_t want);
		oidba_rsp_t calc;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		calc = predict_rsp(r);
		if (r.cmd == CMD_ALLOC && calc.status == ST_OK) begin
			granted_ids.push_back(calc.granted_id);
			if (granted_ids.size() > 24)
				void'(granted_ids.pop_front());
		end
		rsp_due.push_back(typed ? want : calc);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected response: status=%0d granted=%0d alloc=%0b",
						rsp.status, rsp.granted_id, rsp.is_allocated);
			end else begin
				head_rsp = rsp_due.pop_front();
				if (rsp.status !== head_rsp.status || rsp.granted_id !== head_rsp.granted_id
						|| rsp.is_allocated !== head_rsp.is_allocated) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: exp status=%0d granted=%0d alloc=%0b, got status=%0d granted=%0d alloc=%0b",
							head_rsp.status, head_rsp.granted_id, head_rsp.is_allocated,
							rsp.status, rsp.granted_id, rsp.is_allocated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0]       dir_bases;
		logic [NUM_KINDS*SIZE_W-1:0] dir_sizes;

		for (int k = 0; k < NUM_KINDS; k++)
			used_map[k] = '0;
		m_id_count = '0;
		m_enable   = '0;
		m_bases    = '0;
		m_sizes    = '0;
		m_thread   = KIND_W'(1);

		// reset settings: nothing enabled, no valid ids
		add_row(CMD_ALLOC, 0, 0, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_ALLOC, 15, 127, 127, 1, ST_INVALID, 0, 0);
		add_row(CMD_FREE, 0, 0, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_CHECK, 0, 127, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0);
		reset_rows = stim_table.size();
		// kind 0 base 0 size 2, thread kind 1 base 8 size 8, kind 2 empty,
		// kind 3 static, kind 4 wraps past the top id
		add_row(CMD_ALLOC, 0, 0, 0, 1, ST_OK, 0, 0);
		add_row(CMD_ALLOC, 0, 0, 0, 0, ST_OK, 0, 0);
		add_row(CMD_ALLOC, 0, 0, 0, 1, ST_NO_ENTRY, 0, 0);
		add_row(CMD_ALLOC, 2, 0, 0, 1, ST_NO_ENTRY, 0, 0);
		add_row(CMD_ALLOC, 3, 0, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_ALLOC, 9, 0, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_CHECK, 0, 1, 0, 0, ST_OK, 0, 0);
		add_row(CMD_FREE, 0, 1, 0, 0, ST_OK, 0, 0);
		add_row(CMD_CHECK, 0, 1, 0, 0, ST_OK, 0, 0);
		add_row(CMD_FREE, 0, 5, 0, 0, ST_OK, 0, 0);
		add_row(CMD_CHECK, 0, 21, 0, 1, ST_OK, 0, 1);
		add_row(CMD_FREE, 0, 21, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_CHECK, 0, 127, 0, 1, ST_INVALID, 0, 0);
		add_row(CMD_ALLOC, 1, 0, 12, 0, ST_OK, 0, 0);
		add_row(CMD_ALLOC, 1, 0, 12, 0, ST_OK, 0, 0);
		add_row(CMD_ALLOC, 1, 0, 3, 0, ST_OK, 0, 0);
		add_row(CMD_ALLOC, 1, 0, 100, 0, ST_OK, 0, 0);
		for (int n = 0; n < 4; n++)
			add_row(CMD_ALLOC, 4, 0, 0, 0, ST_OK, 0, 0);
		add_row(CMD_CLEAR, 0, 0, 0, 1, ST_OK, 0, 0);

		dir_bases = '0;
		dir_sizes = '0;
		dir_bases[ID_BITS*1 +: ID_BITS] = ID_BITS'(8);
		dir_bases[ID_BITS*2 +: ID_BITS] = ID_BITS'(16);
		dir_bases[ID_BITS*3 +: ID_BITS] = ID_BITS'(20);
		dir_bases[ID_BITS*4 +: ID_BITS] = ID_BITS'(125);
		dir_sizes[SIZE_W*0 +: SIZE_W] = SIZE_W'(2);
		dir_sizes[SIZE_W*1 +: SIZE_W] = SIZE_W'(8);
		dir_sizes[SIZE_W*3 +: SIZE_W] = SIZE_W'(4);
		dir_sizes[SIZE_W*4 +: SIZE_W] = SIZE_W'(8);
		dir_sizes[SIZE_W*5 +: SIZE_W] = SIZE_W'(63);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < stim_table.size(); i++) begin
			if (i == reset_rows) begin
				req_valid <= 1'b0;
				drain();
				load_config(ID_BITS'(127), NUM_KINDS'(9'h017), dir_bases, dir_sizes, KIND_W'(1));
			end
			drive_req(stim_table[i].r, stim_table[i].typed, stim_table[i].want);
		end
		req_valid <= 1'b0;
		drain();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 0)
				load_config('1, '1, '1, '1, '1);
			else if (p == 1)
				load_config('0, '0, '0, '0, '0);
			else
				random_config((p == 2) ? NUM_KINDS - 1 : -1);
			quiet = (p == QUIET_PHASE);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				drive_req(random_req(), 1'b0, '0);
			req_valid <= 1'b0;
			quiet = 1'b0;
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && rsp_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/oidba_pkg.sv
rtl/object_id_bitmap_allocator.sv
tb/object_id_bitmap_allocator_tb.sv
